>>> rtl/trig_ratio_completion_top_defines.svh
// assertion macros used by the top-level rtl file
`ifndef TRIG_RATIO_COMPLETION_TOP_DEFINES_SVH
`define TRIG_RATIO_COMPLETION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define TRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trc assertion failed");
// next-cycle implication, also checked across reset
`define TRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("trc assertion failed");
`else
`define TRC_ASSERT_IMP(lbl, ante, cons)
`define TRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/trc_pkg.sv
`timescale 1ns / 1ps
package trc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int QUOT_W        = 33;
  localparam int OPND_W        = 34;

  localparam logic [1:0] CMD_SIN = 2'd0;
  localparam logic [1:0] CMD_COS = 2'd1;
  localparam logic [1:0] CMD_TAN = 2'd2;
  localparam logic [1:0] CMD_COT = 2'd3;

  localparam logic signed [WORD_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] NEG_MAX = 32'sh8000_0000;

  // raw divider result before saturation
  typedef struct packed {
    logic [QUOT_W-1:0] q;
    logic              ovf;
    logic              bz;
    logic              neg;
    logic              a_neg;
  } div_res_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] val;
    logic                     sat;
  } fx_t;

  // apply sign and saturation to a quotient magnitude
  function automatic fx_t fx_fin(input div_res_t d);
    fx_t f;
    f.sat = 1'b0;
    f.val = '0;
    if (d.bz) begin
      f.sat = 1'b1;
      f.val = d.a_neg ? NEG_MAX : POS_MAX;
    end else if (d.ovf) begin
      f.sat = 1'b1;
      f.val = d.neg ? NEG_MAX : POS_MAX;
    end else if (d.neg) begin
      if (d.q > 33'h0_8000_0000) begin
        f.sat = 1'b1;
        f.val = NEG_MAX;
      end else begin
        f.val = -$signed(d.q[WORD_W-1:0]);
      end
    end else begin
      if (d.q > 33'h0_7FFF_FFFF) begin
        f.sat = 1'b1;
        f.val = POS_MAX;
      end else begin
        f.val = $signed(d.q[WORD_W-1:0]);
      end
    end
    return f;
  endfunction

endpackage

>>> rtl/trc_sqrt.sv
`timescale 1ns / 1ps
module trc_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  output logic [31:0] root
);
  localparam int STAGES = 32;

  logic [63:0] rem_r  [STAGES];
  logic [31:0] root_r [STAGES];

  // one root bit per stage, msb first
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int K = STAGES - 1 - i;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [64:0] trial;
    logic        ge;
    logic [63:0] rem_nxt;
    logic [31:0] root_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = n;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    always_comb begin
      trial    = (65'(root_in) << (K + 1)) + (65'(1) << (2 * K));
      ge       = {1'b0, rem_in} >= trial;
      rem_nxt  = ge ? rem_in - trial[63:0] : rem_in;
      root_nxt = ge ? root_in | (32'(1) << K) : root_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
      end
    end
  end

  assign root = root_r[STAGES-1];
endmodule

>>> rtl/trc_div.sv
`timescale 1ns / 1ps
module trc_div #(
  parameter int FRAC_BITS = trc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [trc_pkg::OPND_W-1:0]   a,
  input  logic signed [trc_pkg::OPND_W-1:0]   b,
  output trc_pkg::div_res_t                   res
);
  import trc_pkg::*;

  localparam int MAG_W  = OPND_W - 1;
  localparam int DW     = MAG_W + FRAC_BITS;
  localparam int CW     = MAG_W + QUOT_W + 1;
  localparam int STAGES = QUOT_W;

  logic [MAG_W-1:0] ma, mb;
  logic [DW-1:0]    dvd;
  logic             ovf_pre;

  // magnitudes and range precheck
  always_comb begin
    ma      = a[OPND_W-1] ? MAG_W'(-a) : MAG_W'(a);
    mb      = b[OPND_W-1] ? MAG_W'(-b) : MAG_W'(b);
    dvd     = DW'(ma) << FRAC_BITS;
    ovf_pre = CW'(dvd) >= (CW'(mb) << QUOT_W);
  end

  logic [MAG_W-1:0] mb_r  [STAGES+1];
  logic [DW-1:0]    rem_r [STAGES+1];
  div_res_t         fl_r  [STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      mb_r[0]        <= mb;
      rem_r[0]       <= dvd;
      fl_r[0].q      <= '0;
      fl_r[0].ovf    <= ovf_pre;
      fl_r[0].bz     <= (b == '0);
      fl_r[0].neg    <= a[OPND_W-1] ^ b[OPND_W-1];
      fl_r[0].a_neg  <= a[OPND_W-1];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam int K = STAGES - 1 - i;
    logic [CW-1:0] dsh;
    logic          ge;
    div_res_t      fl_nxt;
    logic [DW-1:0] rem_nxt;

    always_comb begin
      dsh       = CW'(mb_r[i]) << K;
      ge        = CW'(rem_r[i]) >= dsh;
      rem_nxt   = ge ? rem_r[i] - dsh[DW-1:0] : rem_r[i];
      fl_nxt    = fl_r[i];
      fl_nxt.q  = fl_r[i].q | (ge ? (QUOT_W'(1) << K) : '0);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mb_r[i+1]  <= mb_r[i];
        rem_r[i+1] <= rem_nxt;
        fl_r[i+1]  <= fl_nxt;
      end
    end
  end

  assign res = fl_r[STAGES];
endmodule

>>> rtl/trig_ratio_completion_top.sv
// channel  | handshake              | payload
// in_      | in_valid / in_stall    | in_cmd, in_given_value
// out_     | out_valid / out_stall  | out_sine_out .. out_cotangent_saturated
//
// one transaction accepted per cycle while the output is not stalled
// the pipeline runs through the 32-stage square root and the 34-stage divider lanes
// synchronous active-low reset clears all valid bits, payload is not reset
// a stalled output transaction freezes the whole pipeline and stalls the input
`timescale 1ns / 1ps
`include "trig_ratio_completion_top_defines.svh"
module trig_ratio_completion_top #(
  parameter int FRAC_BITS = trc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic signed [trc_pkg::WORD_W-1:0] in_given_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [trc_pkg::WORD_W-1:0] out_sine_out,
  output logic signed [trc_pkg::WORD_W-1:0] out_cosine_out,
  output logic signed [trc_pkg::WORD_W-1:0] out_tangent_out,
  output logic signed [trc_pkg::WORD_W-1:0] out_cotangent_out,
  output logic                              out_domain_error,
  output logic                              out_tangent_saturated,
  output logic                              out_cotangent_saturated
);
  import trc_pkg::*;

  localparam int SQ_LAT  = 32;
  localparam int DIV_LAT = QUOT_W + 1;

  typedef struct packed {
    logic                     v;
    logic [1:0]               cmd;
    logic signed [WORD_W-1:0] x;
    logic                     dom;
    logic [WORD_W-1:0]        root;
  } sb_t;

  logic adv;
  logic out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage 0: capture and magnitude
  logic                     v0_r;
  logic [1:0]               cmd0_r;
  logic signed [WORD_W-1:0] x0_r;
  logic [WORD_W-1:0]        mx0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd0_r <= in_cmd;
      x0_r   <= in_given_value;
      mx0_r  <= in_given_value[WORD_W-1] ? WORD_W'(-in_given_value)
                                         : WORD_W'(in_given_value);
    end
  end

  // stage 1: square and domain check
  logic                     v1_r, dom1_r;
  logic [1:0]               cmd1_r;
  logic signed [WORD_W-1:0] x1_r;
  logic [63:0]              xsq1_r;
  logic [WORD_W:0]          one_w;

  assign one_w = (WORD_W+1)'(1) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r <= cmd0_r;
      x1_r   <= x0_r;
      xsq1_r <= 64'(mx0_r) * 64'(mx0_r);
      dom1_r <= ((cmd0_r == CMD_SIN) || (cmd0_r == CMD_COS)) && ({1'b0, mx0_r} > one_w);
    end
  end

  // stage 2: radicand
  sb_t         sb2_r;
  logic [63:0] n2_r;
  logic [63:0] one_sq;

  assign one_sq = 64'(1) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb2_r.v <= 1'b0;
    end else if (adv) begin
      sb2_r.v <= v1_r;
    end
    if (adv) begin
      sb2_r.cmd  <= cmd1_r;
      sb2_r.x    <= x1_r;
      sb2_r.dom  <= dom1_r;
      sb2_r.root <= '0;
      if ((cmd1_r == CMD_SIN) || (cmd1_r == CMD_COS)) begin
        n2_r <= dom1_r ? '0 : one_sq - xsq1_r;
      end else begin
        n2_r <= one_sq + xsq1_r;
      end
    end
  end

  // square root with matching sideband line
  logic [WORD_W-1:0] root;
  sb_t               sq_sb_r [SQ_LAT];

  trc_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .n    (n2_r),
    .root (root)
  );

  for (genvar i = 0; i < SQ_LAT; i++) begin : g_sq_sb
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_sb_r[i].v <= 1'b0;
      end else if (adv) begin
        sq_sb_r[i].v <= (i == 0) ? sb2_r.v : sq_sb_r[(i == 0) ? 0 : i-1].v;
      end
      if (adv) begin
        if (i == 0) begin
          sq_sb_r[i].cmd <= sb2_r.cmd;
          sq_sb_r[i].x   <= sb2_r.x;
          sq_sb_r[i].dom <= sb2_r.dom;
        end else begin
          sq_sb_r[i].cmd <= sq_sb_r[(i == 0) ? 0 : i-1].cmd;
          sq_sb_r[i].x   <= sq_sb_r[(i == 0) ? 0 : i-1].x;
          sq_sb_r[i].dom <= sq_sb_r[(i == 0) ? 0 : i-1].dom;
        end
        sq_sb_r[i].root <= '0;
      end
    end
  end

  // stage 3: divider operand select
  sb_t                      sb3_r;
  sb_t                      sq_last;
  logic signed [OPND_W-1:0] a0_r, b0_r, a1_r, b1_r, a2_r, b2_r;
  logic signed [OPND_W-1:0] one_o, x_o, r_o, s_o, c_o;
  logic                     sincos;

  assign sq_last = sq_sb_r[SQ_LAT-1];

  always_comb begin
    one_o  = OPND_W'(1) <<< FRAC_BITS;
    x_o    = OPND_W'(sq_last.x);
    r_o    = $signed({2'b00, root});
    sincos = (sq_last.cmd == CMD_SIN) || (sq_last.cmd == CMD_COS);
    s_o    = (sq_last.cmd == CMD_SIN) ? x_o : r_o;
    c_o    = (sq_last.cmd == CMD_SIN) ? r_o : x_o;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb3_r.v <= 1'b0;
    end else if (adv) begin
      sb3_r.v <= sq_last.v;
    end
    if (adv) begin
      sb3_r.cmd  <= sq_last.cmd;
      sb3_r.x    <= sq_last.x;
      sb3_r.dom  <= sq_last.dom;
      sb3_r.root <= root;
      a0_r <= sincos ? s_o : x_o;
      b0_r <= sincos ? c_o : r_o;
      a1_r <= sincos ? c_o : one_o;
      b1_r <= sincos ? s_o : r_o;
      a2_r <= one_o;
      b2_r <= x_o;
    end
  end

  // three divider lanes
  div_res_t d0, d1, d2;

  trc_div #(.FRAC_BITS(FRAC_BITS)) u_div0 (
    .clk (clk), .en (adv), .a (a0_r), .b (b0_r), .res (d0)
  );
  trc_div #(.FRAC_BITS(FRAC_BITS)) u_div1 (
    .clk (clk), .en (adv), .a (a1_r), .b (b1_r), .res (d1)
  );
  trc_div #(.FRAC_BITS(FRAC_BITS)) u_div2 (
    .clk (clk), .en (adv), .a (a2_r), .b (b2_r), .res (d2)
  );

  sb_t dv_sb_r [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_dv_sb
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_sb_r[i].v <= 1'b0;
      end else if (adv) begin
        dv_sb_r[i].v <= (i == 0) ? sb3_r.v : dv_sb_r[(i == 0) ? 0 : i-1].v;
      end
      if (adv) begin
        if (i == 0) begin
          dv_sb_r[i].cmd  <= sb3_r.cmd;
          dv_sb_r[i].x    <= sb3_r.x;
          dv_sb_r[i].dom  <= sb3_r.dom;
          dv_sb_r[i].root <= sb3_r.root;
        end else begin
          dv_sb_r[i].cmd  <= dv_sb_r[(i == 0) ? 0 : i-1].cmd;
          dv_sb_r[i].x    <= dv_sb_r[(i == 0) ? 0 : i-1].x;
          dv_sb_r[i].dom  <= dv_sb_r[(i == 0) ? 0 : i-1].dom;
          dv_sb_r[i].root <= dv_sb_r[(i == 0) ? 0 : i-1].root;
        end
      end
    end
  end

  // output stage: saturate and route ratios
  sb_t                      dv_last;
  fx_t                      f0, f1, f2;
  logic signed [WORD_W-1:0] s_nxt, c_nxt, t_nxt, k_nxt;
  logic                     dom_nxt, tsat_nxt, ksat_nxt;
  logic signed [WORD_W-1:0] root_s;

  assign dv_last = dv_sb_r[DIV_LAT-1];

  always_comb begin
    f0       = fx_fin(d0);
    f1       = fx_fin(d1);
    f2       = fx_fin(d2);
    root_s   = $signed(dv_last.root);
    s_nxt    = '0;
    c_nxt    = '0;
    t_nxt    = '0;
    k_nxt    = '0;
    dom_nxt  = dv_last.dom;
    tsat_nxt = 1'b0;
    ksat_nxt = 1'b0;
    case (dv_last.cmd) inside
      CMD_SIN, CMD_COS: begin
        if (dv_last.dom) begin
          s_nxt = (dv_last.cmd == CMD_SIN) ? dv_last.x : '0;
          c_nxt = (dv_last.cmd == CMD_COS) ? dv_last.x : '0;
        end else begin
          s_nxt    = (dv_last.cmd == CMD_SIN) ? dv_last.x : root_s;
          c_nxt    = (dv_last.cmd == CMD_SIN) ? root_s : dv_last.x;
          t_nxt    = f0.val;
          k_nxt    = f1.val;
          tsat_nxt = f0.sat;
          ksat_nxt = f1.sat;
        end
      end
      CMD_TAN: begin
        s_nxt    = f0.val;
        c_nxt    = f1.val;
        t_nxt    = dv_last.x;
        k_nxt    = f2.val;
        ksat_nxt = f2.sat;
      end
      default: begin
        c_nxt    = f0.val;
        s_nxt    = f1.val;
        k_nxt    = dv_last.x;
        t_nxt    = f2.val;
        tsat_nxt = f2.sat;
      end
    endcase
  end

  logic signed [WORD_W-1:0] s_r, c_r, t_r, k_r;
  logic                     dom_r, tsat_r, ksat_r;
  logic [1:0]               cmd_o_r;
  logic signed [WORD_W-1:0] x_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_last.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r     <= s_nxt;
      c_r     <= c_nxt;
      t_r     <= t_nxt;
      k_r     <= k_nxt;
      dom_r   <= dom_nxt;
      tsat_r  <= tsat_nxt;
      ksat_r  <= ksat_nxt;
      cmd_o_r <= dv_last.cmd;
      x_o_r   <= dv_last.x;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_sine_out            = s_r;
  assign out_cosine_out          = c_r;
  assign out_tangent_out         = t_r;
  assign out_cotangent_out       = k_r;
  assign out_domain_error        = dom_r;
  assign out_tangent_saturated   = tsat_r;
  assign out_cotangent_saturated = ksat_r;

  // checks on pipeline behavior
  `TRC_ASSERT_IMP(a_dom_no_sat, out_valid_r && dom_r, !tsat_r && !ksat_r && t_r == '0 && k_r == '0)
  `TRC_ASSERT_IMP(a_tan_pass, out_valid_r && cmd_o_r == CMD_TAN, t_r == x_o_r && !tsat_r)
  `TRC_ASSERT_IMP(a_cot_pass, out_valid_r && cmd_o_r == CMD_COT, k_r == x_o_r && !ksat_r)
  `TRC_ASSERT_NEXT(a_rst_clear, !rst_n, !out_valid_r && !v0_r)
endmodule
